// ===== design/imd_pkg.sv =====
// Shared types and constants for the stream metadata splitter.
// Used by the top level, front end, queue and back end and by the checker; no dependencies.
package imd_pkg;

	// Result kind codes, as carried on the output tuser.
	typedef enum logic [1:0] {
		KIND_AUDIO = 2'd0,
		KIND_LEN   = 2'd1,
		KIND_META  = 2'd2
	} kind_t;

	localparam int BYTE_W     = 8;
	localparam int INTERVAL_W = 20;
	localparam int COUNT_W    = 12;
	// A length byte counts blocks of sixteen bytes.
	localparam int BLOCK_UNIT = 4;

	// Configuration register indexes.
	localparam logic [7:0] REG_META_ENABLE   = 8'd0;
	localparam logic [7:0] REG_META_INTERVAL = 8'd1;

	// One classified byte, passed from the front end to the back end.
	typedef struct packed {
		kind_t               kind;
		logic [BYTE_W-1:0]   data;
		logic [COUNT_W-1:0]  pos;
		logic                cmp_ok;   // stored byte at pos belongs to the previous block
		logic                wr_ok;    // pos lies inside the store
		logic                last;     // final metadata byte of the block
		logic                len_diff; // block length differs from the previous block
	} item_t;

endpackage

// ===== design/icy_metadata_demux.sv =====
// Top level of the stream metadata splitter: configuration registers and
// the front end, queue and back end. Depends on imd_pkg, imd_front, imd_queue, imd_back.
//
// Channel  Direction  Signals                        Contents
// s_*      in         s_tvalid s_tready s_tdata      one stream byte
// m_*      out        m_tvalid m_tready m_tdata      byte, kind, last flag, new flag
//                     m_tuser m_tlast
// cfg_*    in         cfg_valid cfg_ready            register index and value
//                     cfg_index cfg_data
//
// One byte is taken every cycle while the queue has room; a result is offered once it has
// passed classification and queue write, store read and the output register.
// The store read and compare-write pair in the back end sets the one-byte-per-cycle rate.
// A stall on the output holds the back end; the two-entry queue then fills and
// lowers s_tready. The store needs no clearing after reset; reset is asynchronous.
module icy_metadata_demux #(
	parameter int META_DEPTH = 4096
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] data_byte
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [7:0]  m_tdata,   // [7:0] out_byte
	output logic [2:0]  m_tuser,   // [1:0] kind, [2] block_new
	output logic        m_tlast,   // block_last
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [7:0]  cfg_index,
	input  logic [19:0] cfg_data
);

	logic                               meta_enable_q;
	logic [imd_pkg::INTERVAL_W-1:0]     meta_interval_q;
	logic                               in_fire;
	imd_pkg::item_t                     front_item;
	imd_pkg::item_t                     head;
	logic                               q_full;
	logic                               q_empty;
	logic                               pop;
	imd_pkg::kind_t                     out_kind;
	logic                               out_new;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			meta_enable_q   <= 1'b1;
			meta_interval_q <= '0;
		end else if (cfg_valid) begin
			case (cfg_index)
				imd_pkg::REG_META_ENABLE:   meta_enable_q   <= cfg_data[0];
				imd_pkg::REG_META_INTERVAL: meta_interval_q <= cfg_data;
				default: ;
			endcase
		end
	end

	assign s_tready = !q_full;
	assign in_fire  = s_tvalid && s_tready;

	imd_front #(
		.META_DEPTH(META_DEPTH)
	) u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.meta_enable  (meta_enable_q),
		.meta_interval(meta_interval_q),
		.in_fire      (in_fire),
		.in_byte      (s_tdata),
		.item         (front_item)
	);

	imd_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (in_fire),
		.push_item(front_item),
		.pop      (pop),
		.head     (head),
		.full     (q_full),
		.empty    (q_empty)
	);

	imd_back #(
		.META_DEPTH(META_DEPTH)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.head     (head),
		.empty    (q_empty),
		.pop      (pop),
		.out_valid(m_tvalid),
		.out_ready(m_tready),
		.out_kind (out_kind),
		.out_byte (m_tdata),
		.out_last (m_tlast),
		.out_new  (out_new)
	);

	assign m_tuser = {out_new, out_kind};

endmodule

// ===== design/imd_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module imd_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 4096
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule

// ===== design/imd_front.sv =====
// Front end: accepts stream bytes, tracks the audio and metadata counters
// and classifies each byte into an item. Depends on imd_pkg.
module imd_front #(
	parameter int META_DEPTH = 4096
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              meta_enable,
	input  logic [imd_pkg::INTERVAL_W-1:0]    meta_interval,
	input  logic                              in_fire,
	input  logic [imd_pkg::BYTE_W-1:0]        in_byte,
	output imd_pkg::item_t                    item
);

	localparam int CW = imd_pkg::COUNT_W;
	localparam logic [CW:0] DEPTH_W = (CW+1)'(META_DEPTH);

	logic [imd_pkg::INTERVAL_W-1:0] audio_count_q, audio_count_d;
	logic [CW-1:0] remaining_q, remaining_d;
	logic [CW-1:0] position_q, position_d;
	logic [CW-1:0] block_len_q, block_len_d;
	logic [CW-1:0] prev_len_q, prev_len_d;
	logic          meta_on;
	logic          in_store;

	assign meta_on  = meta_enable && (meta_interval != '0);
	assign in_store = ({1'b0, position_q} < DEPTH_W);

	always_comb begin
		audio_count_d = audio_count_q;
		remaining_d   = remaining_q;
		position_d    = position_q;
		block_len_d   = block_len_q;
		prev_len_d    = prev_len_q;

		item.kind     = imd_pkg::KIND_AUDIO;
		item.data     = in_byte;
		item.pos      = position_q;
		item.cmp_ok   = 1'b0;
		item.wr_ok    = 1'b0;
		item.last     = 1'b0;
		item.len_diff = 1'b0;

		if (meta_on && (remaining_q == '0) && (audio_count_q >= meta_interval)) begin
			item.kind     = imd_pkg::KIND_LEN;
			audio_count_d = '0;
			remaining_d   = {in_byte, {imd_pkg::BLOCK_UNIT{1'b0}}};
			block_len_d   = {in_byte, {imd_pkg::BLOCK_UNIT{1'b0}}};
			position_d    = '0;
		end else if (meta_enable && (remaining_q != '0)) begin
			item.kind   = imd_pkg::KIND_META;
			item.cmp_ok = (position_q < prev_len_q) && in_store;
			item.wr_ok  = in_store;
			position_d  = position_q + CW'(1);
			remaining_d = remaining_q - CW'(1);
			if (remaining_q == CW'(1)) begin
				item.last     = 1'b1;
				item.len_diff = (block_len_q != prev_len_q);
				prev_len_d    = block_len_q;
			end
		end else if (meta_on) begin
			audio_count_d = audio_count_q + imd_pkg::INTERVAL_W'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			audio_count_q <= '0;
			remaining_q   <= '0;
			position_q    <= '0;
			block_len_q   <= '0;
			prev_len_q    <= '0;
		end else if (in_fire) begin
			audio_count_q <= audio_count_d;
			remaining_q   <= remaining_d;
			position_q    <= position_d;
			block_len_q   <= block_len_d;
			prev_len_q    <= prev_len_d;
		end
	end

endmodule

// ===== design/imd_queue.sv =====
// Two-entry queue of classified items between the front and back ends.
// Depends on imd_pkg.
module imd_queue (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  imd_pkg::item_t push_item,
	input  logic           pop,
	output imd_pkg::item_t head,
	output logic           full,
	output logic           empty
);

	imd_pkg::item_t entry_q [2];
	logic           wr_ptr_q;
	logic           rd_ptr_q;
	logic [1:0]     count_q;

	assign full  = (count_q == 2'd2);
	assign empty = (count_q == 2'd0);
	assign head  = entry_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + 2'd1;
				2'b01:   count_q <= count_q - 2'd1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

// ===== design/imd_back.sv =====
// Back end: reads the stored previous block, compares, writes the new byte
// and drives the output register. Depends on imd_pkg and imd_ram.
module imd_back #(
	parameter int META_DEPTH = 4096
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  imd_pkg::item_t             head,
	input  logic                       empty,
	output logic                       pop,
	output logic                       out_valid,
	input  logic                       out_ready,
	output imd_pkg::kind_t             out_kind,
	output logic [imd_pkg::BYTE_W-1:0] out_byte,
	output logic                       out_last,
	output logic                       out_new
);

	localparam int AW = $clog2(META_DEPTH);

	logic                       adv;
	logic                       valid_s1;
	imd_pkg::item_t             item_s1;
	logic [imd_pkg::BYTE_W-1:0] rd_data;
	logic                       mismatch_q;
	logic                       diff;
	logic                       mismatch_next;
	logic                       is_meta;
	logic                       wr_en;
	logic                       out_valid_q;

	// The stage ahead of the output register moves only when that register is free,
	// so the read data held by the RAM stays aligned with the item in stage one.
	assign adv = !out_valid_q || out_ready;
	assign pop = adv && !empty;

	assign is_meta       = (item_s1.kind == imd_pkg::KIND_META);
	assign diff          = !item_s1.cmp_ok || (rd_data != item_s1.data);
	assign mismatch_next = mismatch_q || diff;
	assign wr_en         = adv && valid_s1 && is_meta && item_s1.wr_ok;

	imd_ram #(
		.WIDTH(imd_pkg::BYTE_W),
		.DEPTH(META_DEPTH)
	) u_store (
		.clk    (clk),
		.wr_en  (wr_en),
		.wr_addr(item_s1.pos[AW-1:0]),
		.wr_data(item_s1.data),
		.rd_en  (pop),
		.rd_addr(head.pos[AW-1:0]),
		.rd_data(rd_data)
	);

	always_ff @(posedge clk) begin
		if (pop) begin
			item_s1 <= head;
		end
		if (adv && valid_s1) begin
			out_kind <= item_s1.kind;
			out_byte <= item_s1.data;
			out_last <= item_s1.last;
			out_new  <= is_meta && item_s1.last && (mismatch_next || item_s1.len_diff);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
			mismatch_q  <= 1'b0;
		end else if (adv) begin
			valid_s1    <= pop;
			out_valid_q <= valid_s1;
			if (valid_s1) begin
				case (item_s1.kind)
					imd_pkg::KIND_LEN:  mismatch_q <= 1'b0;
					imd_pkg::KIND_META: mismatch_q <= item_s1.last ? 1'b0 : mismatch_next;
					default:            mismatch_q <= mismatch_q;
				endcase
			end
		end
	end

	assign out_valid = out_valid_q;

endmodule

// ===== design/imd_checker.sv =====
// Port-level checks for the stream metadata splitter, bound to the top level.
// Depends on imd_pkg and icy_metadata_demux.
module imd_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       m_tvalid,
	input logic       m_tready,
	input logic [7:0] m_tdata,
	input logic [2:0] m_tuser,
	input logic       m_tlast
);

	// The new-block flag is only raised on the final byte of a block.
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser[2] |-> m_tlast)
		else $error("block_new set without block_last");

	// Only metadata bytes can close a block.
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tlast |-> (m_tuser[1:0] == imd_pkg::KIND_META))
		else $error("block_last on a byte that is not metadata");

	// A stalled request keeps its contents.
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
			&& $stable(m_tlast))
		else $error("output changed while stalled");

endmodule

bind icy_metadata_demux imd_checker u_imd_checker (
	.clk     (clk),
	.arst_n  (arst_n),
	.m_tvalid(m_tvalid),
	.m_tready(m_tready),
	.m_tdata (m_tdata),
	.m_tuser (m_tuser),
	.m_tlast (m_tlast)
);
